/* sv/multi_channel_soft_timer_defines.svh */
// Assertion macros for the multi-channel soft timer checker.
// No dependencies; included by the checker file only.
`ifndef MULTI_CHANNEL_SOFT_TIMER_DEFINES_SVH
`define MULTI_CHANNEL_SOFT_TIMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCST_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MCST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/mcst_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the multi-channel soft timer.
// No dependencies; imported by every module of the block.
package mcst_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CHAN_FIELD_W = 3;
    localparam int MASK_W       = 8;
    localparam int TIME_W       = 32;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_START_ONE = 2'd1,
        OP_START_PER = 2'd2,
        OP_DISABLE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CMD_NOP     = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_START   = 2'd2,
        CMD_DISABLE = 2'd3
    } t_cmd_kind;

    typedef struct packed {
        t_op                     op;
        logic [CHAN_FIELD_W-1:0] channel;
        logic [TIME_W-1:0]       period_ms;
    } t_in_word;

    typedef struct packed {
        logic [MASK_W-1:0] fired_mask;
        logic [MASK_W-1:0] running_mask;
        logic [TIME_W-1:0] now_ms;
    } t_out_word;

    // Decoded command handed from the front end to the executor.
    typedef struct packed {
        t_cmd_kind         kind;
        logic              periodic;
        logic [CH_W-1:0]   channel;
        logic [TIME_W-1:0] period;
    } t_cmd;

endpackage

/* sv/mcst_front.sv */
`timescale 1ns / 1ps
// Front end: accepts input words, decodes them into commands, queues them.
// Depends on mcst_pkg.
module mcst_front import mcst_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_word i_word,
    output logic     o_cmd_valid,
    input  logic     i_cmd_ready,
    output t_cmd     o_cmd
);

    t_cmd              dec_cmd;
    logic              in_range;
    logic              push;
    logic              pop;
    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    // Start and disable on a channel that does not exist turn into no-ops.
    always_comb begin
        in_range         = (32'(i_word.channel) < NUM_CHANNELS);
        dec_cmd.channel  = CH_W'(i_word.channel);
        dec_cmd.period   = i_word.period_ms;
        dec_cmd.periodic = (i_word.op == OP_START_PER);
        case (i_word.op)
            OP_TICK:      dec_cmd.kind = CMD_TICK;
            OP_START_ONE: dec_cmd.kind = in_range ? CMD_START : CMD_NOP;
            OP_START_PER: dec_cmd.kind = in_range ? CMD_START : CMD_NOP;
            OP_DISABLE:   dec_cmd.kind = in_range ? CMD_DISABLE : CMD_NOP;
            default:      dec_cmd.kind = CMD_NOP;
        endcase
    end

    assign o_ready     = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_slot[r_rd_ptr];
    assign push        = i_valid && o_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= dec_cmd;
        end
    end

endmodule

/* sv/mcst_back.sv */
`timescale 1ns / 1ps
// Back end: executes queued commands, scans channels on ticks, holds the result word.
// Depends on mcst_pkg.
module mcst_back import mcst_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    output logic      o_cmd_ready,
    input  t_cmd      i_cmd,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_word
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state                  r_state, n_state;
    logic [TIME_W-1:0]       r_time, n_time;
    logic [CH_W-1:0]         r_idx, n_idx;
    logic [NUM_CHANNELS-1:0] r_active, n_active;
    logic [NUM_CHANNELS-1:0] r_periodic, n_periodic;
    logic [NUM_CHANNELS-1:0] r_fired, n_fired;
    logic                    r_out_valid, n_out_valid;
    t_out_word               r_out_word, n_out_word;

    logic [TIME_W-1:0]       r_deadline [NUM_CHANNELS];
    logic [TIME_W-1:0]       r_period   [NUM_CHANNELS];

    logic                    dl_we;
    logic [CH_W-1:0]         dl_addr;
    logic [TIME_W-1:0]       dl_wdata;
    logic                    pr_we;
    logic [TIME_W-1:0]       rd_deadline;
    logic [TIME_W-1:0]       rd_period;
    logic [TIME_W-1:0]       next_deadline;
    logic                    hit;

    assign rd_deadline = r_deadline[r_idx];
    assign rd_period   = r_period[r_idx];
    assign hit         = r_active[r_idx] && !(rd_deadline > r_time);

    always_comb begin
        next_deadline = rd_deadline + rd_period;
        if (next_deadline < r_time) begin
            next_deadline = r_time;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_time      = r_time;
        n_idx       = r_idx;
        n_active    = r_active;
        n_periodic  = r_periodic;
        n_fired     = r_fired;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        o_cmd_ready = 1'b0;
        dl_we       = 1'b0;
        pr_we       = 1'b0;
        dl_addr     = i_cmd.channel;
        dl_wdata    = r_time + i_cmd.period;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_ready = 1'b1;
                    n_fired     = '0;
                    n_state     = ST_DONE;
                    case (i_cmd.kind)
                        CMD_TICK: begin
                            n_time  = r_time + 1'b1;
                            n_idx   = '0;
                            n_state = ST_SCAN;
                        end
                        CMD_START: begin
                            dl_we                      = 1'b1;
                            pr_we                      = 1'b1;
                            n_active[i_cmd.channel]    = 1'b1;
                            n_periodic[i_cmd.channel]  = i_cmd.periodic;
                        end
                        CMD_DISABLE: begin
                            n_active[i_cmd.channel]    = 1'b0;
                            n_periodic[i_cmd.channel]  = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                dl_addr  = r_idx;
                dl_wdata = next_deadline;
                if (hit) begin
                    n_fired[r_idx] = 1'b1;
                    if (r_periodic[r_idx]) begin
                        dl_we = 1'b1;
                    end else begin
                        n_active[r_idx] = 1'b0;
                    end
                end
                if (r_idx == CH_W'(NUM_CHANNELS - 1)) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid             = 1'b1;
                    n_out_word.fired_mask   = MASK_W'(r_fired);
                    n_out_word.running_mask = MASK_W'(r_active);
                    n_out_word.now_ms       = r_time;
                    n_state                 = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_time      <= '0;
            r_idx       <= '0;
            r_active    <= '0;
            r_periodic  <= '0;
            r_fired     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_time      <= n_time;
            r_idx       <= n_idx;
            r_active    <= n_active;
            r_periodic  <= n_periodic;
            r_fired     <= n_fired;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
        if (dl_we) begin
            r_deadline[dl_addr] <= dl_wdata;
        end
        if (pr_we) begin
            r_period[dl_addr] <= i_cmd.period;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out_word;

endmodule

/* sv/multi_channel_soft_timer.sv */
`timescale 1ns / 1ps
// Top level of the multi-channel soft timer: front end, command queue and executor.
// Depends on mcst_pkg, mcst_front and mcst_back.
//
// Usage: each input word carries an operation (tick, start one-shot, start
// periodic, disable), a channel number and a period in milliseconds. Every
// input word produces exactly one output word with the fired mask, the
// running mask and the current millisecond count.
// Both channels use valid/ready; a word moves when valid and ready are high
// at the same rising edge. Input words go into a two-entry command queue, so
// the block keeps taking words while the executor is busy or the output
// register is waiting for the receiver.
// A start, disable or ignored word goes from the idle state straight to the
// done state; a tick first passes through the scan state, because the
// executor scans the channel deadlines one per cycle with a single
// add-and-compare unit. That scan sets the sustained tick rate.
// Reset (synchronous, active low) clears time, all channel flags, the queue
// and the output valid flag. Deadlines and periods are not cleared; a channel
// reads them only after a start has written them.
// When the receiver stalls, the finished word holds in the output register,
// the executor waits with its next result and the queue fills; the input
// ready drops once both queue entries are taken.
module multi_channel_soft_timer import mcst_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_word,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_word
);

    logic cmd_valid;
    logic cmd_ready;
    t_cmd cmd;

    // Decode and buffer incoming words.
    mcst_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_word      (i_word),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    // Execute commands and present one result word per command.
    mcst_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_word      (o_word)
    );

endmodule

/* sv/mcst_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the multi-channel soft timer, bound to the top level.
// Depends on mcst_pkg and multi_channel_soft_timer_defines.svh.
`include "multi_channel_soft_timer_defines.svh"

module mcst_checker import mcst_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input t_in_word  i_in_word,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_word i_out_word
);

    logic [TIME_W-1:0] r_last_now;
    logic              out_take;

    assign out_take = i_out_valid && i_out_ready;

    // Time reported by the previous delivered word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_now <= '0;
        end else if (out_take) begin
            r_last_now <= i_out_word.now_ms;
        end
    end

    `MCST_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_word), "output word changed while stalled")

    `MCST_ASSERT_NOW(a_time_step, i_clk, i_rst_n, out_take,
        (i_out_word.now_ms == r_last_now) || (i_out_word.now_ms == r_last_now + 1'b1),
        "time moved by more than one tick between results")

    `MCST_ASSERT_NOW(a_fire_on_tick, i_clk, i_rst_n, out_take && (i_out_word.fired_mask != '0),
        i_out_word.now_ms == r_last_now + 1'b1,
        "channels fired on a result that did not advance time")

    `MCST_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_in_valid && !i_in_ready,
        i_in_valid && $stable(i_in_word), "input word changed while waiting")

endmodule

bind multi_channel_soft_timer mcst_checker u_mcst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_valid),
    .i_in_ready  (o_ready),
    .i_in_word   (i_word),
    .i_out_valid (o_valid),
    .i_out_ready (i_ready),
    .i_out_word  (o_word)
);
